[src/pvu_pkg.sv]
// Shared types, widths and constants of the particle velocity and position update.
package pvu_pkg;

  localparam int VAL_W      = 32;
  localparam int DIFF_W     = VAL_W + 1;
  localparam int ITER_W     = 16;
  localparam int RAND_W     = 16;
  localparam int COEF_W     = 16;
  localparam int LIM_W      = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // The ramp ratio is computed as floor(tc * 2^RAMP_FRAC / run_length).
  localparam int RAMP_FRAC   = 13;
  localparam int DIV_STEPS   = RAMP_FRAC + 1;
  localparam int W_RAMP_DROP = 2;

  localparam logic [COEF_W-1:0] W_MIN  = 16'd1638;
  localparam logic [COEF_W-1:0] C_HIGH = 16'd10240;
  localparam logic [COEF_W-1:0] C_LOW  = 16'd2048;

  localparam int FRAC_SHIFT = 12;
  localparam int WV_W       = COEF_W + 1 + VAL_W;
  localparam int PRD_W      = COEF_W + 1 + DIFF_W;
  localparam int SUM_W      = PRD_W + 2;
  localparam int SH_W       = SUM_W - FRAC_SHIFT;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int DEF_VALUE_BITS = 32;
  localparam int DEF_COEFF_BITS = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INERTIA_WEIGHT,
    CFG_ACCEL_COEFF,
    CFG_VELOCITY_LIMIT,
    CFG_POSITION_LIMIT,
    CFG_RUN_LENGTH,
    CFG_INERTIA_MODE,
    CFG_ACCEL_MODE,
    CFG_USE_GLOBAL_BEST
  } cfg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0] inertia_weight;
    logic [COEF_W-1:0] accel_coeff;
    logic [LIM_W-1:0]  velocity_limit;
    logic [LIM_W-1:0]  position_limit;
    logic [ITER_W-1:0] run_length;
    logic              inertia_mode;
    logic              accel_mode;
    logic              use_global_best;
  } cfg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  x;
    logic signed [VAL_W-1:0]  v;
    logic signed [DIFF_W-1:0] d1;
    logic signed [DIFF_W-1:0] d2;
    logic [RAND_W-1:0]        r1;
    logic [RAND_W-1:0]        r2;
  } front_pay_t;

  typedef struct packed {
    front_pay_t        pay;
    logic [COEF_W-1:0] w;
    logic [COEF_W-1:0] c1;
    logic [COEF_W-1:0] c2;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[src/pvu_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface pvu_in_if;
  logic                                valid;
  logic                                ready;
  logic [pvu_pkg::ITER_W-1:0]          iteration;
  logic signed [pvu_pkg::VAL_W-1:0]    position;
  logic signed [pvu_pkg::VAL_W-1:0]    velocity;
  logic signed [pvu_pkg::VAL_W-1:0]    personal_best;
  logic signed [pvu_pkg::VAL_W-1:0]    informant_best;
  logic signed [pvu_pkg::VAL_W-1:0]    global_best;
  logic [pvu_pkg::RAND_W-1:0]          rand_one;
  logic [pvu_pkg::RAND_W-1:0]          rand_two;

  modport source (
    output valid, iteration, position, velocity, personal_best, informant_best,
           global_best, rand_one, rand_two,
    input  ready
  );
  modport sink (
    input  valid, iteration, position, velocity, personal_best, informant_best,
           global_best, rand_one, rand_two,
    output ready
  );
endinterface

interface pvu_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [pvu_pkg::VAL_W-1:0] new_position;
  logic signed [pvu_pkg::VAL_W-1:0] new_velocity;
  logic                             position_clamped;

  modport source (
    output valid, new_position, new_velocity, position_clamped,
    input  ready
  );
  modport sink (
    input  valid, new_position, new_velocity, position_clamped,
    output ready
  );
endinterface

[src/pvu_frac_div.sv]
// Pipelined restoring divider, one quotient bit per stage, for num <= den.
module pvu_frac_div (
  input  logic                            clk,
  input  logic                            en,
  input  logic [pvu_pkg::ITER_W-1:0]      num,
  input  logic [pvu_pkg::ITER_W-1:0]      den,
  output logic [pvu_pkg::DIV_STEPS-1:0]   quot
);

  localparam int OPW   = pvu_pkg::ITER_W;
  localparam int STEPS = pvu_pkg::DIV_STEPS;

  logic [OPW-1:0]   rem_r  [STEPS-1];
  logic [OPW-1:0]   den_r  [STEPS-1];
  logic [STEPS-1:0] quot_r [STEPS];

  logic first_ge;
  assign first_ge = num >= den;

  // Since num never exceeds den, the first stage yields the integer bit only.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= first_ge ? OPW'(num - den) : num;
      den_r[0]  <= den;
      quot_r[0] <= {{(STEPS-1){1'b0}}, first_ge};
    end
  end

  for (genvar k = 1; k < STEPS; k++) begin : g_stage
    logic [OPW:0] trial;
    logic         ge;

    assign trial = {rem_r[k-1], 1'b0};
    assign ge    = trial >= {1'b0, den_r[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        quot_r[k] <= {quot_r[k-1][STEPS-2:0], ge};
      end
    end

    if (k < STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? OPW'(trial - {1'b0, den_r[k-1]}) : trial[OPW-1:0];
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign quot = quot_r[STEPS-1];

endmodule

[src/pvu_front.sv]
// Front end: accepts items, forms differences and computes the schedule coefficients.
module pvu_front #(
  parameter int COEFF_BITS = pvu_pkg::DEF_COEFF_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  pvu_in_if.sink            in_ch,
  input  pvu_pkg::cfg_t     cfg,
  input  pvu_pkg::q_stat_t  q_stat,
  output logic              q_push,
  output pvu_pkg::work_t    q_data
);

  localparam int STEPS = pvu_pkg::DIV_STEPS;
  localparam int CW    = pvu_pkg::COEF_W;
  localparam logic [CW-1:0] COEF_MASK = CW'((64'd1 << COEFF_BITS) - 64'd1);

  logic                       front_en;
  logic                       accept;
  logic [pvu_pkg::ITER_W-1:0] rl_eff;
  logic [pvu_pkg::ITER_W-1:0] tc;
  logic [pvu_pkg::ITER_W-1:0] rest;
  logic [STEPS-1:0]           qc;
  logic [STEPS-1:0]           qw;
  logic signed [pvu_pkg::VAL_W-1:0] att;
  pvu_pkg::front_pay_t        pay_in;

  logic [STEPS-1:0]           vld_r;
  pvu_pkg::front_pay_t        pay_r [STEPS];

  // The whole front advances together; it holds while the queue is full.
  // No transfer is offered while reset is held.
  assign front_en    = !q_stat.full;
  assign in_ch.ready = front_en && rst_n;
  assign accept      = in_ch.valid && in_ch.ready;

  // A zero run length behaves as a ratio that has already reached one.
  always_comb begin
    if (cfg.run_length == '0) begin
      rl_eff = pvu_pkg::ITER_W'(1);
      tc     = pvu_pkg::ITER_W'(1);
    end else begin
      rl_eff = cfg.run_length;
      tc     = (in_ch.iteration < cfg.run_length) ? in_ch.iteration : cfg.run_length;
    end
    rest = rl_eff - tc;
  end

  assign att = cfg.use_global_best ? in_ch.global_best : in_ch.informant_best;

  always_comb begin
    pay_in.x  = in_ch.position;
    pay_in.v  = in_ch.velocity;
    pay_in.d1 = {in_ch.personal_best[pvu_pkg::VAL_W-1], in_ch.personal_best}
              - {in_ch.position[pvu_pkg::VAL_W-1], in_ch.position};
    pay_in.d2 = {att[pvu_pkg::VAL_W-1], att}
              - {in_ch.position[pvu_pkg::VAL_W-1], in_ch.position};
    pay_in.r1 = in_ch.rand_one;
    pay_in.r2 = in_ch.rand_two;
  end

  // The inertia ramp is the acceleration ramp of (rl - tc) scaled down by four.
  pvu_frac_div u_div_accel (
    .clk  (clk),
    .en   (front_en),
    .num  (tc),
    .den  (rl_eff),
    .quot (qc)
  );

  pvu_frac_div u_div_inertia (
    .clk  (clk),
    .en   (front_en),
    .num  (rest),
    .den  (rl_eff),
    .quot (qw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (front_en) begin
      vld_r <= {vld_r[STEPS-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      pay_r[0] <= pay_in;
      for (int k = 1; k < STEPS; k++) begin
        pay_r[k] <= pay_r[k-1];
      end
    end
  end

  assign q_push = front_en && vld_r[STEPS-1];

  always_comb begin
    q_data.pay = pay_r[STEPS-1];
    if (cfg.inertia_mode) begin
      q_data.w = pvu_pkg::W_MIN + CW'(qw >> pvu_pkg::W_RAMP_DROP);
    end else begin
      q_data.w = cfg.inertia_weight & COEF_MASK;
    end
    if (cfg.accel_mode) begin
      q_data.c1 = pvu_pkg::C_HIGH - CW'(qc);
      q_data.c2 = pvu_pkg::C_LOW + CW'(qc);
    end else begin
      q_data.c1 = cfg.accel_coeff & COEF_MASK;
      q_data.c2 = cfg.accel_coeff & COEF_MASK;
    end
  end

endmodule

[src/pvu_fifo.sv]
// Short queue between the front end and the arithmetic back end.
module pvu_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pvu_pkg::work_t    push_data,
  input  logic              pop,
  output pvu_pkg::work_t    head,
  output pvu_pkg::q_stat_t  q_stat
);

  localparam int DEPTH = pvu_pkg::QUEUE_DEPTH;
  localparam int PW    = pvu_pkg::QPTR_W;

  pvu_pkg::work_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [PW:0]    cnt_r;
  logic [PW:0]    cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (PW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = cnt_r == (PW+1)'(DEPTH);
  assign q_stat.empty = cnt_r == '0;

endmodule

[src/pvu_back.sv]
// Back end: velocity sum, saturation, clamps and the output register.
module pvu_back #(
  parameter int VALUE_BITS = pvu_pkg::DEF_VALUE_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pvu_pkg::cfg_t     cfg,
  input  pvu_pkg::work_t    head,
  input  pvu_pkg::q_stat_t  q_stat,
  output logic              q_pop,
  pvu_out_if.source         out_ch
);

  localparam int VW  = pvu_pkg::VAL_W;
  localparam int DW  = pvu_pkg::DIFF_W;
  localparam int CW  = pvu_pkg::COEF_W;
  localparam int RW  = pvu_pkg::RAND_W;
  localparam int SHW = pvu_pkg::SH_W;

  logic back_en;
  logic [3:0] vld_r;
  logic       out_vld_r;

  // Stage 1: random scaling of the coefficients and the inertia term.
  logic [RW+CW-1:0]                 phi1_c;
  logic [RW+CW-1:0]                 phi2_c;
  logic signed [pvu_pkg::WV_W-1:0]  wv_c;
  logic [CW-1:0]                    phi1_r;
  logic [CW-1:0]                    phi2_r;
  logic signed [pvu_pkg::WV_W-1:0]  wv1_r;
  logic signed [DW-1:0]             d1_r;
  logic signed [DW-1:0]             d2_r;
  logic signed [VW-1:0]             x1_r;

  // Stage 2: attraction terms.
  logic signed [pvu_pkg::PRD_W-1:0] p1_c;
  logic signed [pvu_pkg::PRD_W-1:0] p2_c;
  logic signed [pvu_pkg::PRD_W-1:0] p1_r;
  logic signed [pvu_pkg::PRD_W-1:0] p2_r;
  logic signed [pvu_pkg::WV_W-1:0]  wv2_r;
  logic signed [VW-1:0]             x2_r;

  // Stage 3: sum and floor shift.
  logic signed [pvu_pkg::SUM_W-1:0] sum_c;
  logic signed [SHW-1:0]            sh_r;
  logic signed [VW-1:0]             x3_r;

  // Stage 4: saturation and velocity clamp.
  logic signed [SHW-1:0]            vsat;
  logic signed [SHW-1:0]            vmax_c;
  logic signed [SHW-1:0]            vmin_c;
  logic signed [SHW-1:0]            vcl;
  logic signed [VW-1:0]             v4_r;
  logic signed [VW-1:0]             x4_r;

  // Output stage: position update and clamp.
  logic signed [VW:0]               xs;
  logic signed [VW:0]               xmax_c;
  logic signed [VW:0]               xmin_c;
  logic                             over_hi;
  logic                             over_lo;
  logic signed [VW-1:0]             pos_r;
  logic signed [VW-1:0]             vel_r;
  logic                             clamp_r;

  assign back_en = !out_vld_r || out_ch.ready;
  assign q_pop   = back_en && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (back_en) begin
      vld_r     <= {vld_r[2:0], q_pop};
      out_vld_r <= vld_r[3];
    end
  end

  assign phi1_c = head.pay.r1 * head.c1;
  assign phi2_c = head.pay.r2 * head.c2;
  assign wv_c   = $signed({1'b0, head.w}) * head.pay.v;

  always_ff @(posedge clk) begin
    if (back_en) begin
      phi1_r <= phi1_c[RW+CW-1:RW];
      phi2_r <= phi2_c[RW+CW-1:RW];
      wv1_r  <= wv_c;
      d1_r   <= head.pay.d1;
      d2_r   <= head.pay.d2;
      x1_r   <= head.pay.x;
    end
  end

  assign p1_c = $signed({1'b0, phi1_r}) * d1_r;
  assign p2_c = $signed({1'b0, phi2_r}) * d2_r;

  always_ff @(posedge clk) begin
    if (back_en) begin
      p1_r  <= p1_c;
      p2_r  <= p2_c;
      wv2_r <= wv1_r;
      x2_r  <= x1_r;
    end
  end

  // Dropping the low bits of a two's complement sum rounds toward minus infinity.
  assign sum_c = pvu_pkg::SUM_W'(wv2_r) + pvu_pkg::SUM_W'(p1_r) + pvu_pkg::SUM_W'(p2_r);

  always_ff @(posedge clk) begin
    if (back_en) begin
      sh_r <= $signed(sum_c[pvu_pkg::SUM_W-1:pvu_pkg::FRAC_SHIFT]);
      x3_r <= x2_r;
    end
  end

  if (VALUE_BITS < SHW) begin : g_sat
    localparam logic signed [SHW-1:0] SAT_HI =
      SHW'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
    localparam logic signed [SHW-1:0] SAT_LO = ~SAT_HI;

    assign vsat = (sh_r > SAT_HI) ? SAT_HI : ((sh_r < SAT_LO) ? SAT_LO : sh_r);
  end else begin : g_nosat
    assign vsat = sh_r;
  end

  assign vmax_c = $signed({{(SHW-pvu_pkg::LIM_W){1'b0}}, cfg.velocity_limit});
  assign vmin_c = -vmax_c;
  assign vcl    = (vsat > vmax_c) ? vmax_c : ((vsat < vmin_c) ? vmin_c : vsat);

  always_ff @(posedge clk) begin
    if (back_en) begin
      v4_r <= vcl[VW-1:0];
      x4_r <= x3_r;
    end
  end

  assign xs      = {x4_r[VW-1], x4_r} + {v4_r[VW-1], v4_r};
  assign xmax_c  = $signed({{(VW+1-pvu_pkg::LIM_W){1'b0}}, cfg.position_limit});
  assign xmin_c  = -xmax_c;
  assign over_hi = xs > xmax_c;
  assign over_lo = xs < xmin_c;

  always_ff @(posedge clk) begin
    if (back_en) begin
      if (over_hi) begin
        pos_r <= xmax_c[VW-1:0];
      end else if (over_lo) begin
        pos_r <= xmin_c[VW-1:0];
      end else begin
        pos_r <= xs[VW-1:0];
      end
      vel_r   <= (over_hi || over_lo) ? '0 : v4_r;
      clamp_r <= over_hi || over_lo;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.new_position     = pos_r;
  assign out_ch.new_velocity     = vel_r;
  assign out_ch.position_clamped = clamp_r;

endmodule

[src/pso_velocity_position_update.sv]
// Top level of the particle swarm velocity and position update, with its register bank.
//
// Each input item updates one dimension of one particle and gives exactly one result,
// in order. The block takes one item per clock and delivers one result per clock while
// the output side keeps ready high. On its way to a result an item passes the front end,
// which has 14 stages, set by the pipelined divider that forms the time ratio one
// quotient bit per stage, and whose first stage loads at the transfer edge itself; then
// the queue; then the back end (two multiplier stages, the sum, the clamps, the output
// register). A stalled output fills the four-entry queue and the front end holds when
// it is full. Input ready is low while reset is held. Registers are written through the
// cfg_ port one per clock and take effect for items transferred afterwards; change them
// only while no item is in flight.
module pso_velocity_position_update #(
  parameter int VALUE_BITS = pvu_pkg::DEF_VALUE_BITS,
  parameter int COEFF_BITS = pvu_pkg::DEF_COEFF_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pvu_in_if.sink                            in_ch,
  pvu_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [pvu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pvu_pkg::CFG_DATA_W-1:0]    cfg_data
);

  pvu_pkg::cfg_t    cfg_r;
  pvu_pkg::work_t   q_wdata;
  pvu_pkg::work_t   q_head;
  pvu_pkg::q_stat_t q_stat;
  logic             q_push;
  logic             q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inertia_weight  <= pvu_pkg::COEF_W'(2949);
      cfg_r.accel_coeff     <= pvu_pkg::COEF_W'(8192);
      cfg_r.velocity_limit  <= pvu_pkg::LIM_W'(65536);
      cfg_r.position_limit  <= pvu_pkg::LIM_W'(655360);
      cfg_r.run_length      <= pvu_pkg::ITER_W'(1000);
      cfg_r.inertia_mode    <= 1'b0;
      cfg_r.accel_mode      <= 1'b0;
      cfg_r.use_global_best <= 1'b0;
    end else if (cfg_we) begin
      case (pvu_pkg::cfg_idx_t'(cfg_index))
        pvu_pkg::CFG_INERTIA_WEIGHT:  cfg_r.inertia_weight  <= cfg_data[pvu_pkg::COEF_W-1:0];
        pvu_pkg::CFG_ACCEL_COEFF:     cfg_r.accel_coeff     <= cfg_data[pvu_pkg::COEF_W-1:0];
        pvu_pkg::CFG_VELOCITY_LIMIT:  cfg_r.velocity_limit  <= cfg_data[pvu_pkg::LIM_W-1:0];
        pvu_pkg::CFG_POSITION_LIMIT:  cfg_r.position_limit  <= cfg_data[pvu_pkg::LIM_W-1:0];
        pvu_pkg::CFG_RUN_LENGTH:      cfg_r.run_length      <= cfg_data[pvu_pkg::ITER_W-1:0];
        pvu_pkg::CFG_INERTIA_MODE:    cfg_r.inertia_mode    <= cfg_data[0];
        pvu_pkg::CFG_ACCEL_MODE:      cfg_r.accel_mode      <= cfg_data[0];
        pvu_pkg::CFG_USE_GLOBAL_BEST: cfg_r.use_global_best <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pvu_front #(
    .COEFF_BITS (COEFF_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  pvu_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head      (q_head),
    .q_stat    (q_stat)
  );

  pvu_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .head   (q_head),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
